// ===== rtl/pbc_pkg.sv =====
package pbc_pkg;

    localparam int CM_W            = 5;
    localparam int AM_W            = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int NUM_COLOR_MODES = 18;
    localparam int NUM_ALPHA_MODES = 14;

    typedef enum logic [CM_W-1:0] {
        CM_OVER,
        CM_COPY,
        CM_UNDER,
        CM_ATOP,
        CM_IN,
        CM_OUT,
        CM_SCREEN,
        CM_ADD,
        CM_SUBTRACT,
        CM_MULTIPLY,
        CM_MAX,
        CM_MIN,
        CM_AVERAGE,
        CM_DIFFERENCE,
        CM_OVERLAY,
        CM_SOFT_LIGHT,
        CM_DIVIDE,
        CM_XOR
    } color_mode_t;

    typedef enum logic [AM_W-1:0] {
        AM_OVER,
        AM_UNDER,
        AM_ATOP,
        AM_IN,
        AM_OUT,
        AM_SCREEN,
        AM_ADD,
        AM_SUBTRACT,
        AM_MULTIPLY,
        AM_MAX,
        AM_MIN,
        AM_AVERAGE,
        AM_DIFFERENCE,
        AM_XOR
    } alpha_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_MODE,
        CFG_ALPHA_MODE,
        CFG_FORE_OPACITY,
        CFG_BACK_OPACITY,
        CFG_MASK_SCALE,
        CFG_ALPHA_ENABLE
    } cfg_idx_t;

    function automatic color_mode_t alpha_to_color(input logic [AM_W-1:0] am);
        color_mode_t cm;
        case (am)
            AM_OVER:       cm = CM_OVER;
            AM_UNDER:      cm = CM_UNDER;
            AM_ATOP:       cm = CM_ATOP;
            AM_IN:         cm = CM_IN;
            AM_OUT:        cm = CM_OUT;
            AM_SCREEN:     cm = CM_SCREEN;
            AM_ADD:        cm = CM_ADD;
            AM_SUBTRACT:   cm = CM_SUBTRACT;
            AM_MULTIPLY:   cm = CM_MULTIPLY;
            AM_MAX:        cm = CM_MAX;
            AM_MIN:        cm = CM_MIN;
            AM_AVERAGE:    cm = CM_AVERAGE;
            AM_DIFFERENCE: cm = CM_DIFFERENCE;
            AM_XOR:        cm = CM_XOR;
            default:       cm = CM_OVER;
        endcase
        return cm;
    endfunction

endpackage

// ===== rtl/pixel_blend_compositor_top.sv =====
// Throughput: one pixel per cycle while the output is not stalled; the divide and square-root
// stages, one bit each, set latency.
// The whole pipeline holds while a result waits and m_axis_tready is low.
// Reset (rst_n low, asynchronous) empties the pipeline and loads the register defaults:
// modes over, the three scales 1.0, alpha disabled.
module pixel_blend_compositor_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fore_red, fore_green, fore_blue, fore_alpha, back_red, back_green,
    // back_blue, back_alpha, mask_value
    input  logic [8*((9*DATA_WIDTH+7)/8)-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [8*((4*DATA_WIDTH+7)/8)-1:0]   m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [FRAC_BITS+1:0]                cfg_data
);

    import pbc_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int SCW   = F + 2;
    localparam int BW    = (W > F + 3) ? W : F + 3;
    localparam int MW    = W + BW + 1;
    localparam int QW    = W + F;
    localparam int XW    = W - 1 + F;
    localparam int SW    = XW + (XW % 2);
    localparam int R     = SW / 2;
    localparam int RW    = R + 3;
    localparam int DS    = QW;
    localparam int NL    = 4;
    localparam int QS    = 6;
    localparam int NIN   = 9;
    localparam int OUT_W = 8 * ((4 * W + 7) / 8);

    localparam logic signed [MW-1:0] ONE_M  = {{(MW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [MW-1:0] HALF_M = {{(MW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [MW-1:0] SMAX   = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [MW-1:0] SMIN   = {{(MW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [BW-1:0] HALF_B = BW'(HALF_M);
    localparam logic [SCW-1:0]       SC_ONE = {2'b01, {F{1'b0}}};

    typedef struct packed {
        logic                on;
        color_mode_t         mode;
        logic signed [W-1:0] a1;
        logic signed [W-1:0] a2;
        logic signed [W-1:0] f;
        logic signed [W-1:0] base;
        logic signed [W-1:0] b;
        logic signed [W-1:0] m;
    } lane_t;

    typedef struct packed {
        logic [W:0]    rem;
        logic [QW-1:0] nq;
        logic [W-1:0]  den;
        logic          neg;
        logic          zero;
        logic [RW-1:0] srem;
        logic [SW-1:0] sx;
        logic [R-1:0]  root;
    } it_t;

    typedef struct packed {
        logic                on;
        color_mode_t         mode;
        logic signed [W-1:0] a2;
        logic signed [W-1:0] f;
        logic signed [W-1:0] base;
        logic signed [W-1:0] b;
        logic signed [W-1:0] m;
        logic signed [W-1:0] divv;
        logic signed [W-1:0] sqv;
        logic signed [W-1:0] oma1;
        logic signed [W-1:0] oma2;
        logic signed [W-1:0] omb;
        logic signed [W-1:0] omf;
        logic signed [W-1:0] ff;
        logic signed [W-1:0] bb;
        logic signed [W-1:0] d2;
        logic signed [W-1:0] omff;
        logic signed [W-1:0] ffm1;
        logic signed [W-1:0] fpb;
        logic signed [W-1:0] absd;
        logic signed [W-1:0] omm;
        logic signed [W-1:0] p_boma1;
        logic signed [W-1:0] p_foma2;
        logic signed [W-1:0] p_fa2;
        logic signed [W-1:0] p_scr;
        logic signed [W-1:0] p_fb;
        logic signed [W-1:0] p_avg;
        logic signed [W-1:0] p_ffb;
        logic signed [W-1:0] p_ov;
        logic signed [W-1:0] p_bb;
        logic signed [W-1:0] p_bbf;
        logic signed [W-1:0] p_sq;
        logic signed [W-1:0] p_sl2;
        logic signed [W-1:0] v;
        logic signed [W-1:0] pv;
        logic signed [W-1:0] pb;
        logic signed [W-1:0] res;
    } ops_t;

    function automatic logic signed [W-1:0] sat(input logic signed [MW-1:0] x);
        logic signed [W-1:0] r;
        if (x > SMAX)
        begin
            r = SMAX[W-1:0];
        end
        else if (x < SMIN)
        begin
            r = SMIN[W-1:0];
        end
        else
        begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] mul(input logic signed [W-1:0] a,
                                                input logic signed [BW-1:0] b);
        logic signed [MW-1:0] p;
        p = MW'(a) * MW'(b) + HALF_M;
        p = p >>> F;
        return sat(p);
    endfunction

    function automatic logic signed [W-1:0] mul_w(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return mul(a, BW'(b));
    endfunction

    function automatic logic signed [W-1:0] mul_s(input logic signed [W-1:0] a,
                                                  input logic [SCW-1:0] s);
        return mul(a, BW'($signed({1'b0, s})));
    endfunction

    function automatic logic signed [W-1:0] add(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        return sat(MW'(a) + MW'(b));
    endfunction

    function automatic logic signed [W-1:0] sub(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        return sat(MW'(a) - MW'(b));
    endfunction

    function automatic logic signed [W-1:0] sub_one(input logic signed [W-1:0] x);
        return sat(ONE_M - MW'(x));
    endfunction

    function automatic logic signed [W-1:0] clamp01(input logic signed [W-1:0] x);
        logic signed [W-1:0] r;
        if (x[W-1])
        begin
            r = '0;
        end
        else if (MW'(x) > ONE_M)
        begin
            r = W'(ONE_M);
        end
        else
        begin
            r = x;
        end
        return r;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic it_t it_step(input it_t x, input logic do_sq);
        it_t           y;
        logic [W:0]    r;
        logic [RW-1:0] sr;
        logic [RW-1:0] tr;
        y = x;
        r = {x.rem[W-1:0], x.nq[QW-1]};
        y.nq = {x.nq[QW-2:0], 1'b0};
        if (r >= {1'b0, x.den})
        begin
            r = r - {1'b0, x.den};
            y.nq[0] = 1'b1;
        end
        y.rem = r;
        sr = {x.srem[RW-3:0], x.sx[SW-1:SW-2]};
        tr = RW'({x.root, 2'b01});
        if (do_sq)
        begin
            y.sx = {x.sx[SW-3:0], 2'b00};
            if (sr >= tr)
            begin
                y.srem = sr - tr;
                y.root = {x.root[R-2:0], 1'b1};
            end
            else
            begin
                y.srem = sr;
                y.root = {x.root[R-2:0], 1'b0};
            end
        end
        return y;
    endfunction

    logic [CM_W-1:0] color_mode_reg;
    logic [AM_W-1:0] alpha_mode_reg;
    logic [SCW-1:0]  fore_opacity_reg;
    logic [SCW-1:0]  back_opacity_reg;
    logic [SCW-1:0]  mask_scale_reg;
    logic            alpha_enable_reg;

    logic                adv;
    logic                p0_v_reg;
    logic signed [W-1:0] p0_in_reg [NIN];
    logic                p1_v_reg;
    logic signed [W-1:0] p1_f_reg [3];
    logic signed [W-1:0] p1_b_reg [3];
    logic signed [W-1:0] p1_base_reg [3];
    logic signed [W-1:0] p1_fas_reg;
    logic signed [W-1:0] p1_ba_reg;
    logic signed [W-1:0] p1_bal_reg;
    logic signed [W-1:0] p1_mraw_reg;

    logic [DS:0] ch_v_reg;
    lane_t       ch_lane_reg [DS+1][NL];
    it_t         ch_it_reg [DS+1][NL];
    lane_t       ch_lane_next [NL];
    it_t         ch_it_next [NL];

    logic [QS-1:0] q_v_reg;
    ops_t          q_reg [QS][NL];
    ops_t          q_next [QS][NL];

    assign cfg_ready     = 1'b1;
    assign adv           = !q_v_reg[QS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = q_v_reg[QS-1];
    assign m_axis_tdata  = OUT_W'({q_reg[QS-1][3].res, q_reg[QS-1][2].res,
                                   q_reg[QS-1][1].res, q_reg[QS-1][0].res});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg   <= '0;
            alpha_mode_reg   <= '0;
            fore_opacity_reg <= SC_ONE;
            back_opacity_reg <= SC_ONE;
            mask_scale_reg   <= SC_ONE;
            alpha_enable_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COLOR_MODE:   color_mode_reg   <= cfg_data[CM_W-1:0];
                CFG_ALPHA_MODE:   alpha_mode_reg   <= cfg_data[AM_W-1:0];
                CFG_FORE_OPACITY: fore_opacity_reg <= cfg_data;
                CFG_BACK_OPACITY: back_opacity_reg <= cfg_data;
                CFG_MASK_SCALE:   mask_scale_reg   <= cfg_data;
                CFG_ALPHA_ENABLE: alpha_enable_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_v_reg <= 1'b0;
            p1_v_reg <= 1'b0;
            ch_v_reg <= '0;
            q_v_reg  <= '0;
        end
        else if (adv)
        begin
            p0_v_reg <= s_axis_tvalid;
            p1_v_reg <= p0_v_reg;
            ch_v_reg <= {ch_v_reg[DS-1:0], p1_v_reg};
            q_v_reg  <= {q_v_reg[QS-2:0], ch_v_reg[DS]};
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (l < 3)
            begin
                ch_lane_next[l].on   = (color_mode_reg < NUM_COLOR_MODES);
                ch_lane_next[l].mode = color_mode_t'(color_mode_reg);
                ch_lane_next[l].a1   = clamp01(p1_fas_reg);
                ch_lane_next[l].a2   = clamp01(p1_bal_reg);
                ch_lane_next[l].f    = p1_f_reg[l];
                ch_lane_next[l].base = p1_base_reg[l];
                ch_lane_next[l].b    = p1_b_reg[l];
            end
            else
            begin
                ch_lane_next[l].on   = alpha_enable_reg && (alpha_mode_reg < NUM_ALPHA_MODES);
                ch_lane_next[l].mode = alpha_to_color(alpha_mode_reg);
                ch_lane_next[l].a1   = p1_fas_reg;
                ch_lane_next[l].a2   = p1_ba_reg;
                ch_lane_next[l].f    = p1_fas_reg;
                ch_lane_next[l].base = p1_ba_reg;
                ch_lane_next[l].b    = p1_bal_reg;
            end
            ch_lane_next[l].m    = clamp01(p1_mraw_reg);
            ch_it_next[l].rem    = '0;
            ch_it_next[l].nq     = {mag(ch_lane_next[l].b), {F{1'b0}}};
            ch_it_next[l].den    = mag(ch_lane_next[l].f);
            ch_it_next[l].neg    = ch_lane_next[l].b[W-1] ^ ch_lane_next[l].f[W-1];
            ch_it_next[l].zero   = (ch_lane_next[l].f == '0);
            ch_it_next[l].srem   = '0;
            ch_it_next[l].root   = '0;
            if (!ch_lane_next[l].b[W-1] && (ch_lane_next[l].b != '0))
            begin
                ch_it_next[l].sx = SW'({ch_lane_next[l].b[W-2:0], {F{1'b0}}});
            end
            else
            begin
                ch_it_next[l].sx = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NIN; i++)
            begin
                p0_in_reg[i] <= s_axis_tdata[i*W +: W];
            end
            for (int k = 0; k < 3; k++)
            begin
                p1_f_reg[k]    <= mul_s(p0_in_reg[k], fore_opacity_reg);
                p1_b_reg[k]    <= mul_s(p0_in_reg[4+k], back_opacity_reg);
                p1_base_reg[k] <= p0_in_reg[4+k];
            end
            p1_fas_reg  <= mul_s(p0_in_reg[3], fore_opacity_reg);
            p1_ba_reg   <= p0_in_reg[7];
            p1_bal_reg  <= mul_s(p0_in_reg[7], back_opacity_reg);
            p1_mraw_reg <= mul_s(p0_in_reg[8], mask_scale_reg);
            for (int l = 0; l < NL; l++)
            begin
                ch_lane_reg[0][l] <= ch_lane_next[l];
                ch_it_reg[0][l]   <= ch_it_next[l];
                for (int s = 0; s < DS; s++)
                begin
                    ch_lane_reg[s+1][l] <= ch_lane_reg[s][l];
                    ch_it_reg[s+1][l]   <= it_step(ch_it_reg[s][l], s < R);
                end
                for (int s = 0; s < QS; s++)
                begin
                    q_reg[s][l] <= q_next[s][l];
                end
            end
        end
    end

    always_comb
    begin
        ops_t                 o;
        lane_t                ln;
        it_t                  it;
        logic signed [MW-1:0] qm;
        logic signed [MW-1:0] dm;
        for (int l = 0; l < NL; l++)
        begin
            ln = ch_lane_reg[DS][l];
            it = ch_it_reg[DS][l];
            o = '0;
            o.on   = ln.on;
            o.mode = ln.mode;
            o.a2   = ln.a2;
            o.f    = ln.f;
            o.base = ln.base;
            o.b    = ln.b;
            o.m    = ln.m;
            qm = MW'(it.nq);
            if (it.zero)
            begin
                o.divv = sat(ONE_M);
            end
            else
            begin
                o.divv = sat(it.neg ? -qm : qm);
            end
            o.sqv  = sat(MW'(it.root));
            o.oma1 = sub_one(ln.a1);
            o.oma2 = sub_one(ln.a2);
            o.omb  = sub_one(ln.b);
            o.omf  = sub_one(ln.f);
            o.ff   = add(ln.f, ln.f);
            o.bb   = add(ln.b, ln.b);
            o.d2   = add(o.omf, o.omf);
            o.omff = sub_one(o.ff);
            o.ffm1 = sat(MW'(o.ff) - ONE_M);
            o.fpb  = add(ln.f, ln.b);
            dm     = MW'(sub(ln.f, ln.b));
            o.absd = sat(dm[MW-1] ? -dm : dm);
            o.omm  = sub_one(ln.m);
            q_next[0][l] = o;

            o = q_reg[0][l];
            o.p_boma1 = mul_w(o.b, o.oma1);
            o.p_foma2 = mul_w(o.f, o.oma2);
            o.p_fa2   = mul_w(o.f, o.a2);
            o.p_scr   = mul_w(o.omb, o.omf);
            o.p_fb    = mul_w(o.f, o.b);
            o.p_avg   = mul(o.fpb, HALF_B);
            o.p_ffb   = mul_w(o.ff, o.b);
            o.p_ov    = mul_w(o.d2, o.omb);
            o.p_bb    = mul_w(o.b, o.b);
            o.p_bbf   = mul_w(o.bb, o.omf);
            o.p_sq    = mul_w(o.sqv, o.ffm1);
            q_next[1][l] = o;

            o = q_reg[1][l];
            o.p_sl2 = mul_w(o.p_bb, o.omff);
            q_next[2][l] = o;

            o = q_reg[2][l];
            case (o.mode)
                CM_OVER:       o.v = add(o.f, o.p_boma1);
                CM_COPY:       o.v = o.f;
                CM_UNDER:      o.v = add(o.b, o.p_foma2);
                CM_ATOP:       o.v = add(o.p_fa2, o.p_boma1);
                CM_IN:         o.v = o.p_fa2;
                CM_OUT:        o.v = o.p_foma2;
                CM_SCREEN:     o.v = sub_one(o.p_scr);
                CM_ADD:        o.v = add(o.f, o.b);
                CM_SUBTRACT:   o.v = sub(o.b, o.f);
                CM_MULTIPLY:   o.v = o.p_fb;
                CM_MAX:        o.v = (o.f > o.b) ? o.f : o.b;
                CM_MIN:        o.v = (o.f < o.b) ? o.f : o.b;
                CM_AVERAGE:    o.v = o.p_avg;
                CM_DIFFERENCE: o.v = o.absd;
                CM_OVERLAY:    o.v = (MW'(o.base) < HALF_M) ? o.p_ffb : sub_one(o.p_ov);
                CM_SOFT_LIGHT: o.v = (MW'(o.f) < HALF_M) ? add(o.p_ffb, o.p_sl2)
                                                           : add(o.p_bbf, o.p_sq);
                CM_DIVIDE:     o.v = o.divv;
                CM_XOR:        o.v = add(o.p_foma2, o.p_boma1);
                default:       o.v = '0;
            endcase
            q_next[3][l] = o;

            o = q_reg[3][l];
            o.pv = mul_w(o.v, o.m);
            o.pb = mul_w(o.base, o.omm);
            q_next[4][l] = o;

            o = q_reg[4][l];
            o.res = o.on ? add(o.pv, o.pb) : '0;
            q_next[5][l] = o;
        end
    end

endmodule
